// File: rtl/core/psq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the paced scancode queue.
// No dependencies; used by psq_cell and paced_scancode_queue.
package psq_pkg;

  // One scancode
  typedef logic [7:0] code_t;

  // Input command codes
  typedef enum logic {
    CmdPush = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 8;
  localparam logic [CfgIdxWidth-1:0] CfgPacingLines = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgNullCode    = 8'd1;

  // Reset contents: two preloaded codes and the pacing defaults
  localparam code_t PreloadCode0 = 8'hFD;
  localparam code_t PreloadCode1 = 8'hFE;
  localparam code_t EmptyCode    = 8'h00;
  localparam code_t PacingReset  = 8'd10;
  localparam code_t NullReset    = 8'hFF;

  // Per-cycle control seen by every cell of the queue
  typedef struct packed {
    logic shift;  // pop: every cell takes its upstream neighbor's contents
    logic load;   // push: the first empty cell captures the key byte
  } cell_ctrl_t;

  // Serial-port encoding: rotate left by one, then invert
  function automatic code_t serial_encode(code_t code);
    serial_encode = ~{code[6:0], code[7]};
  endfunction

endpackage

// File: rtl/core/psq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the shifting scancode queue.
// Depends on psq_pkg for the code and control types.
module psq_cell #(
  parameter logic           INIT_VALID = 1'b0,
  parameter psq_pkg::code_t INIT_CODE  = 8'h00
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psq_pkg::cell_ctrl_t  ctrl_i,
  input  logic                 prev_valid_i,  // cell nearer the head
  input  logic                 next_valid_i,  // cell nearer the tail
  input  psq_pkg::code_t       next_code_i,
  input  psq_pkg::code_t       key_i,
  output logic                 valid_o,
  output psq_pkg::code_t       code_o
);

  logic           valid_q, valid_d;
  psq_pkg::code_t code_q, code_d;

  // Pop moves the tail neighbor in; push fills the first hole
  always_comb begin
    valid_d = valid_q;
    code_d  = code_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      code_d  = next_code_i;
    end else if (ctrl_i.load && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      code_d  = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= INIT_VALID;
      code_q  <= INIT_CODE;
    end else begin
      valid_q <= valid_d;
      code_q  <= code_d;
    end
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

endmodule

// File: rtl/core/paced_scancode_queue.sv
`timescale 1ns / 1ps
// Top level of the paced scancode queue: cell chain, pacing counter, output register.
// Depends on psq_pkg and psq_cell.

// Keyboard scancode queue with paced delivery. A push (cmd 0) appends key_byte to a
// queue of QUEUE_DEPTH codes; a push into a full queue is dropped. A line tick (cmd 1)
// does nothing on an empty queue; otherwise it counts the wait counter down, and when
// the counter is at one or zero it reloads from pacing_lines and pops the head code.
// A popped code equal to null_code is discarded; any other one is delivered once with
// serial_byte = ~rotl1(raw_code). After reset the queue holds 0xFD then 0xFE, and
// pacing_lines = 10, null_code = 0xFF. The queue is a row of cells that all shift one
// place toward the head on a pop, so the head code is always in the first cell and
// every item completes in the cycle it is accepted: one item per clock, with the result
// in the output register on the next cycle. Input transfers stall only while a result
// waits in that register and out_ready_i is low. Configuration writes are always taken.
module paced_scancode_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [psq_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [7:0]                     key_byte_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     serial_byte_o,
  output logic [7:0]                     raw_code_o
);

  logic                 cell_valid [QUEUE_DEPTH+1];
  psq_pkg::code_t       cell_code  [QUEUE_DEPTH+1];
  psq_pkg::cell_ctrl_t  cell_ctrl;

  psq_pkg::code_t pacing_q, pacing_d;
  psq_pkg::code_t null_q, null_d;
  psq_pkg::code_t wait_q, wait_d;
  logic           out_valid_q, out_valid_d;
  psq_pkg::code_t serial_q, serial_d;
  psq_pkg::code_t raw_q, raw_d;

  logic in_xfer, is_tick, has_code, pop_due, emit;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  // Decode the accepted item
  assign is_tick  = (psq_pkg::cmd_e'(cmd_i) == psq_pkg::CmdTick);
  assign has_code = cell_valid[0];
  assign pop_due  = in_xfer && is_tick && has_code && (wait_q <= 8'd1);
  assign emit     = pop_due && (cell_code[0] != null_q);

  assign cell_ctrl.shift = pop_due;
  assign cell_ctrl.load  = in_xfer && (psq_pkg::cmd_e'(cmd_i) == psq_pkg::CmdPush);

  // Past the tail: an always-empty position
  assign cell_valid[QUEUE_DEPTH] = 1'b0;
  assign cell_code[QUEUE_DEPTH]  = psq_pkg::EmptyCode;

  // Cell chain, head at position 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic           InitValid = (i < 2);
    localparam psq_pkg::code_t InitCode  = (i == 0) ? psq_pkg::PreloadCode0 :
                                           (i == 1) ? psq_pkg::PreloadCode1 :
                                                      psq_pkg::EmptyCode;
    logic prev_valid;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    psq_cell #(
      .INIT_VALID (InitValid),
      .INIT_CODE  (InitCode)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (cell_valid[i+1]),
      .next_code_i  (cell_code[i+1]),
      .key_i        (key_byte_i),
      .valid_o      (cell_valid[i]),
      .code_o       (cell_code[i])
    );
  end

  // Configuration registers; unknown indexes are ignored
  always_comb begin
    pacing_d = pacing_q;
    null_d   = null_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        psq_pkg::CfgPacingLines: pacing_d = cfg_data_i;
        psq_pkg::CfgNullCode:    null_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Wait counter: counts down per tick while the queue holds a code, reloads on a pop
  always_comb begin
    wait_d = wait_q;
    if (in_xfer && is_tick && has_code) begin
      wait_d = (wait_q > 8'd1) ? wait_q - 8'd1 : pacing_q;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    serial_d    = serial_q;
    raw_d       = raw_q;
    if (emit) begin
      out_valid_d = 1'b1;
      serial_d    = psq_pkg::serial_encode(cell_code[0]);
      raw_d       = cell_code[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pacing_q    <= psq_pkg::PacingReset;
      null_q      <= psq_pkg::NullReset;
      wait_q      <= psq_pkg::PacingReset;
      out_valid_q <= 1'b0;
    end else begin
      pacing_q    <= pacing_d;
      null_q      <= null_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    serial_q <= serial_d;
    raw_q    <= raw_d;
  end

  assign out_valid_o   = out_valid_q;
  assign serial_byte_o = serial_q;
  assign raw_code_o    = raw_q;

endmodule

// File: bench/paced_scancode_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the paced scancode queue: random and directed push/tick traffic,
// a cycle-level model of the queue and pacing counter, and a checker on the result port.
// Depends on psq_pkg and the paced_scancode_queue RTL.
module paced_scancode_queue_tb;

  localparam int unsigned QueueDepth   = 64;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned ReportLimit  = 10;
  // An index that maps to no register; writes to it must be ignored
  localparam logic [psq_pkg::CfgIdxWidth-1:0] CfgNoSuchReg = 8'hA5;

  typedef struct {
    psq_pkg::cmd_e  cmd;
    psq_pkg::code_t key;
  } key_event_t;

  typedef struct packed {
    psq_pkg::code_t serial_byte;
    psq_pkg::code_t raw_code;
  } delivery_t;

  // DUT connections
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [psq_pkg::CfgIdxWidth-1:0] cfg_index_i   = '0;
  logic [7:0]                      cfg_data_i    = '0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_ready_o;
  logic                            cmd_i         = 1'b0;
  logic [7:0]                      key_byte_i    = '0;
  logic                            out_valid_o;
  logic                            out_ready_i   = 1'b1;
  logic [7:0]                      serial_byte_o;
  logic [7:0]                      raw_code_o;

  // Stimulus and checking state
  key_event_t      key_events_q[$];
  delivery_t       pending_deliveries[$];
  psq_pkg::code_t  held_codes[$];
  logic [7:0]      pace_left   = psq_pkg::PacingReset;
  logic [7:0]      pacing_reg  = psq_pkg::PacingReset;
  logic [7:0]      null_reg    = psq_pkg::NullReset;
  logic            item_taken  = 1'b0;
  bit              gaps_on     = 1'b1;
  bit              stalls_on   = 1'b1;
  int unsigned items_queued, items_accepted, pushes_seen, ticks_seen;
  int unsigned deliveries_checked, null_drops, full_drops, cfg_writes;
  int unsigned backpressure_cycles, error_count, cycle_count;
  int unsigned send_gap, stall_left, hold_left, holds_requested, holds_served;
  key_event_t  next_event;
  delivery_t   want;

  paced_scancode_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_byte_i   (key_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .serial_byte_o(serial_byte_o),
    .raw_code_o   (raw_code_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic note_failure(input string what);
    error_count++;
    if (error_count <= ReportLimit) $display("ERROR: %s", what);
  endtask

  // Queue model: apply one accepted item, record the delivery it causes, if any
  task automatic predict_delivery(input psq_pkg::cmd_e cmd, input psq_pkg::code_t key);
    psq_pkg::code_t popped;
    psq_pkg::code_t encoded;
    if (cmd == psq_pkg::CmdPush) begin
      pushes_seen++;
      if (held_codes.size() < QueueDepth) held_codes.push_back(key);
      else full_drops++;
    end else begin
      ticks_seen++;
      // ticks on an empty queue leave the counter alone
      if (held_codes.size() != 0) begin
        if (pace_left > 8'd1) begin
          pace_left--;
        end else begin
          pace_left = pacing_reg;
          popped    = held_codes.pop_front();
          encoded   = ~{popped[6:0], popped[7]};
          if (popped == null_reg) null_drops++;
          else pending_deliveries.push_back('{serial_byte: encoded, raw_code: popped});
        end
      end
    end
  endtask

  // Monitor: register writes, input transfers and result transfers at the rising edge
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d deliveries still due", cycle_count,
               pending_deliveries.size());
      $display("paced_scancode_queue test failed");
      $finish;
    end else if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          psq_pkg::CfgPacingLines: pacing_reg = cfg_data_i;
          psq_pkg::CfgNullCode:    null_reg   = cfg_data_i;
          default: ;
        endcase
      end
      // results leave through the output register after their item, so check before predicting
      if (out_valid_o && out_ready_i) begin
        if (pending_deliveries.size() == 0) begin
          note_failure($sformatf("unexpected delivery serial %02h raw %02h",
                                 serial_byte_o, raw_code_o));
        end else begin
          want = pending_deliveries.pop_front();
          deliveries_checked++;
          if (serial_byte_o !== want.serial_byte || raw_code_o !== want.raw_code)
            note_failure($sformatf("expected serial %02h raw %02h, got serial %02h raw %02h",
                                   want.serial_byte, want.raw_code,
                                   serial_byte_o, raw_code_o));
        end
      end
      if (in_valid_i && !in_ready_o) backpressure_cycles++;
      if (in_valid_i && in_ready_o) begin
        items_accepted++;
        predict_delivery(psq_pkg::cmd_e'(cmd_i), key_byte_i);
        item_taken <= 1'b1;
      end else begin
        item_taken <= 1'b0;
      end
    end
  end

  // Driver: offers queued items at the falling edge, with random idle bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !item_taken) begin
      // hold the current item until its transfer
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(1, 18) - 1;
      in_valid_i <= 1'b0;
    end else if (key_events_q.size() != 0) begin
      next_event = key_events_q.pop_front();
      in_valid_i <= 1'b1;
      cmd_i      <= next_event.cmd;
      key_byte_i <= next_event.key;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random stall bursts, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void queue_event(input psq_pkg::cmd_e cmd, input psq_pkg::code_t key);
    key_events_q.push_back('{cmd: cmd, key: key});
    items_queued++;
  endfunction

  // Wait until every item went in and every delivery came out, then let the block settle
  task automatic wait_idle();
    while (items_accepted != items_queued || pending_deliveries.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [psq_pkg::CfgIdxWidth-1:0] idx,
                           input psq_pkg::code_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: push runs, tick runs of up to twice the pacing (at least two), queue-filling
  // bursts, and single items of either kind as noise
  task automatic gen_traffic(input int n, input psq_pkg::code_t pacing,
                             input psq_pkg::code_t nullc, input int push_pct);
    int             left;
    int             run;
    int             r;
    int             pace_span;
    bit             is_push;
    psq_pkg::code_t key;
    left      = n;
    pace_span = (pacing < 2) ? 2 : 2 * pacing;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        is_push = 1'b1;
        run     = QueueDepth + 6;
      end else if (r < 15) begin
        is_push = 1'($urandom_range(0, 1));
        run     = 1;
      end else if (r < 15 + push_pct) begin
        is_push = 1'b1;
        run     = $urandom_range(1, 12);
      end else begin
        is_push = 1'b0;
        run     = $urandom_range(1, pace_span);
      end
      if (run > left) run = left;
      repeat (run) begin
        r = $urandom_range(0, 15);
        if (!is_push) key = 8'($urandom_range(0, 255));
        else if (r < 2) key = nullc;
        else if (r == 2) key = 8'h00;
        else if (r == 3) key = 8'hFF;
        else key = 8'($urandom_range(0, 255));
        queue_event(is_push ? psq_pkg::CmdPush : psq_pkg::CmdTick, key);
      end
      left -= run;
    end
  endtask

  task automatic run_phase(input psq_pkg::code_t pacing, input psq_pkg::code_t nullc,
                           input int n, input int push_pct, input bit gaps,
                           input bit stalls);
    wait_idle();
    write_reg(psq_pkg::CfgPacingLines, pacing);
    write_reg(psq_pkg::CfgNullCode, nullc);
    @(posedge clk_i);
    gaps_on   = gaps;
    stalls_on = stalls;
    gen_traffic(n, pacing, nullc, push_pct);
  endtask

  // Stimulus sequence
  initial begin
    psq_pkg::code_t nullc;
    held_codes = '{psq_pkg::PreloadCode0, psq_pkg::PreloadCode1};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extreme key bytes behind the preload, then a full pacing interval
    queue_event(psq_pkg::CmdPush, 8'hFF);
    queue_event(psq_pkg::CmdPush, 8'h00);
    repeat (10) queue_event(psq_pkg::CmdTick, 8'($urandom_range(0, 255)));
    wait_idle();

    // Pacing 0 waits for the running count first, then pops on every tick;
    // null code 0 is swallowed and 0xFF is now delivered; last tick hits an empty queue
    write_reg(psq_pkg::CfgPacingLines, 8'd0);
    write_reg(psq_pkg::CfgNullCode, 8'h00);
    write_reg(CfgNoSuchReg, 8'($urandom_range(0, 255)));
    repeat (13) queue_event(psq_pkg::CmdTick, 8'($urandom_range(0, 255)));

    run_phase(8'd1, 8'hFF, 350, 40, 1'b1, 1'b1);
    run_phase(8'd255, 8'h00, 300, 15, 1'b1, 1'b0);
    nullc = 8'($urandom_range(0, 255));
    run_phase(8'd3, nullc, 300, 40, 1'b0, 1'b1);

    // Long receiver hold-off while the sender keeps offering
    nullc = 8'($urandom_range(0, 255));
    run_phase(8'd1, nullc, 250, 40, 1'b0, 1'b0);
    holds_requested++;

    run_phase(8'd0, 8'h80, 250, 40, 1'b1, 1'b1);
    nullc = 8'($urandom_range(0, 255));
    run_phase(8'($urandom_range(1, 6)), nullc, 300, 40, 1'b0, 1'b0);

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (pending_deliveries.size() != 0)
      note_failure($sformatf("%0d deliveries never arrived", pending_deliveries.size()));

    $display("Ran %0d items (%0d pushes, %0d ticks) over %0d register writes;",
             items_accepted, pushes_seen, ticks_seen, cfg_writes);
    $display("%0d deliveries checked, %0d null codes swallowed, %0d full-queue drops,",
             deliveries_checked, null_drops, full_drops);
    $display("%0d input stall cycles.", backpressure_cycles);
    if (error_count == 0) begin
      $display("paced_scancode_queue test passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("paced_scancode_queue test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/psq_pkg.sv
rtl/core/psq_cell.sv
rtl/core/paced_scancode_queue.sv
bench/paced_scancode_queue_tb.sv
